FILE: rtl/rbd_pkg.sv
// Shared types and constants for the ring buffer deque.
// Depends on nothing; every other RTL file imports this package.
`default_nettype none

package rbd_pkg;

    // Width of the data words held in the deque.
    localparam int WORD_W = 32;

    // Width of the occupancy field reported with each result.
    localparam int OCC_W = 5;

    // Value returned by a pop that finds the deque empty.
    localparam logic signed [WORD_W-1:0] EMPTY_VALUE = -32'sd1;

    // Operation codes carried by each request.
    typedef enum logic [1:0] {
        ACT_PUSH_FRONT = 2'd0,
        ACT_POP_FRONT  = 2'd1,
        ACT_PUSH_BACK  = 2'd2,
        ACT_POP_BACK   = 2'd3
    } action_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;   // take the request on the input and execute it
        logic finish;   // load the memory read data into the result register
    } rbd_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pop_read;   // the offered request is a pop that must read the store
        logic out_valid;  // the result register holds an undelivered result
    } rbd_status_t;

endpackage

`default_nettype wire

FILE: rtl/ring_buffer_deque_top.sv
// Results: a push or a pop on an empty deque shows its result in the cycle after acceptance;
// a pop that removes a word passes the registered store read, then the result register.
// Throughput: one push per cycle while the result side is not stalled; a pop that
// removes a word holds off the next request until the registered store read completes.
// Reset: pointers and count clear at once, the deque is empty and ready with no clearing
// pass; store contents stay unspecified until written.
`default_nettype none

module ring_buffer_deque_top
    import rbd_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic [1:0]               action,
    input  wire logic signed [WORD_W-1:0] push_value,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic signed [WORD_W-1:0]      pop_value,
    output logic                          was_empty,
    output logic                          was_full,
    output logic [OCC_W-1:0]              occupancy
);

    rbd_cmd_t    cmd;
    rbd_status_t status;

    // Sequencing of requests and store reads.
    rbd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // Pointers, store and result register.
    rbd_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .action     (action),
        .push_value (push_value),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .pop_value  (pop_value),
        .was_empty  (was_empty),
        .was_full   (was_full),
        .occupancy  (occupancy)
    );

endmodule

`default_nettype wire

FILE: rtl/rbd_ctrl.sv
// Controller state machine for the ring buffer deque.
// Depends on rbd_pkg for the command and status structs.
`default_nettype none

module rbd_ctrl
    import rbd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        out_stall,
    input  wire rbd_status_t status,
    output rbd_cmd_t         cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   slot_free;
    logic   accept;

    // The result register can take a new result when it is empty or being drained.
    assign slot_free = !status.out_valid || !out_stall;

    // A request is taken only in idle and only when its result has somewhere to go.
    assign in_stall = !((state_reg == ST_IDLE) && slot_free);
    assign accept   = in_valid && !in_stall;

    assign cmd.accept = accept;
    assign cmd.finish = (state_reg == ST_READ);

    // Next-state logic: a pop that reads the store passes through the read state while it waits for data.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && status.pop_read)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // A pop that reads the store is followed by exactly one finish cycle.
    a_pop_then_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && status.pop_read) |=> cmd.finish)
        else $error("pop read was not followed by a finish cycle");

    a_finish_single: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> !cmd.finish)
        else $error("finish lasted more than one cycle");

    // When read data lands, the result register must already be free.
    a_finish_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !status.out_valid)
        else $error("finish found the result register occupied");

endmodule

`default_nettype wire

FILE: rtl/rbd_datapath.sv
// Datapath of the ring buffer deque: pointers, count, word store and result register.
// Depends on rbd_pkg; driven by commands from rbd_ctrl.
`default_nettype none

module rbd_datapath
    import rbd_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire rbd_cmd_t                 cmd,
    output rbd_status_t                   status,
    input  wire logic [1:0]               action,
    input  wire logic signed [WORD_W-1:0] push_value,
    input  wire logic                     out_stall,
    output logic                          out_valid,
    output logic signed [WORD_W-1:0]      pop_value,
    output logic                          was_empty,
    output logic                          was_full,
    output logic [OCC_W-1:0]              occupancy
);

    localparam int PTR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(CAPACITY - 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CAPACITY);

    // Circular pointer steps.
    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        return (p == LAST_SLOT) ? '0 : p + PTR_W'(1);
    endfunction

    function automatic logic [PTR_W-1:0] wrap_dec(input logic [PTR_W-1:0] p);
        return (p == '0) ? LAST_SLOT : p - PTR_W'(1);
    endfunction

    logic [WORD_W-1:0] word_store [CAPACITY];

    logic [PTR_W-1:0] head_reg;
    logic [PTR_W-1:0] head_next;
    logic [PTR_W-1:0] tail_reg;
    logic [PTR_W-1:0] tail_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    logic signed [WORD_W-1:0] pop_value_reg;
    logic                     was_empty_reg;
    logic                     was_full_reg;
    logic [OCC_W-1:0]         occupancy_reg;
    logic [WORD_W-1:0]        rd_data_reg;

    action_t          act;
    logic             is_push;
    logic             is_full;
    logic             is_empty;
    logic             wr_en;
    logic [PTR_W-1:0] wr_addr;
    logic [PTR_W-1:0] rd_addr;
    logic             load_direct;

    assign act      = action_t'(action);
    assign is_push  = (act == ACT_PUSH_FRONT) || (act == ACT_PUSH_BACK);
    assign is_full  = (count_reg == FULL_COUNT);
    assign is_empty = (count_reg == '0);

    assign status.pop_read  = !is_push && !is_empty;
    assign status.out_valid = out_valid_reg;

    // Pushes and empty pops produce their result at once; other pops wait for the store.
    assign load_direct = cmd.accept && !status.pop_read;

    // Pointer, count and store address updates for the offered request.
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        wr_en      = 1'b0;
        wr_addr    = tail_reg;
        rd_addr    = head_reg;
        case (act)
            ACT_PUSH_FRONT:
            begin
                wr_addr = wrap_dec(head_reg);
                if (!is_full)
                begin
                    head_next  = wrap_dec(head_reg);
                    wr_en      = cmd.accept;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            ACT_PUSH_BACK:
            begin
                wr_addr = tail_reg;
                if (!is_full)
                begin
                    tail_next  = wrap_inc(tail_reg);
                    wr_en      = cmd.accept;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            ACT_POP_FRONT:
            begin
                rd_addr = head_reg;
                if (!is_empty)
                begin
                    head_next  = wrap_inc(head_reg);
                    count_next = count_reg - CNT_W'(1);
                end
            end
            default:
            begin
                rd_addr = wrap_dec(tail_reg);
                if (!is_empty)
                begin
                    tail_next  = wrap_dec(tail_reg);
                    count_next = count_reg - CNT_W'(1);
                end
            end
        endcase
    end

    // The result register empties when taken and fills on a new result.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_direct || cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                head_reg  <= head_next;
                tail_reg  <= tail_next;
                count_reg <= count_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // Word store with one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            word_store[wr_addr] <= push_value;
        end
        if (cmd.accept)
        begin
            rd_data_reg <= word_store[rd_addr];
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (load_direct)
        begin
            pop_value_reg <= is_push ? '0 : EMPTY_VALUE;
            was_empty_reg <= !is_push;
            was_full_reg  <= is_push && is_full;
            occupancy_reg <= OCC_W'(count_next);
        end
        else if (cmd.finish)
        begin
            pop_value_reg <= rd_data_reg;
            was_empty_reg <= 1'b0;
            was_full_reg  <= 1'b0;
            occupancy_reg <= OCC_W'(count_reg);
        end
    end

    assign out_valid = out_valid_reg;
    assign pop_value = pop_value_reg;
    assign was_empty = was_empty_reg;
    assign was_full  = was_full_reg;
    assign occupancy = occupancy_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("held count exceeds capacity");

    // An empty deque has its pointers meeting.
    a_empty_pointers: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (head_reg == tail_reg))
        else $error("empty deque with head and tail apart");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && is_push && !is_full) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("accepted push did not grow the count");

endmodule

`default_nettype wire

FILE: verif/testbench.sv
// Self-checking testbench for ring_buffer_deque_top, a fixed-capacity double-ended queue.
// Depends on rbd_pkg for the word width, the occupancy width and the action codes.
// A local deque predictor checks every result; stimulus mixes directed cases and random runs.
`timescale 1ns / 100ps

module testbench;
    import rbd_pkg::*;

    localparam int DEPTH = 16;
    localparam int CLK_PERIOD = 10;

    // One predicted or observed result of a request.
    typedef struct packed {
        logic signed [WORD_W-1:0] pop_value;
        logic                     was_empty;
        logic                     was_full;
        logic [OCC_W-1:0]         occupancy;
    } deque_result_t;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic [1:0]               action;
    logic signed [WORD_W-1:0] push_value;
    logic                     out_valid;
    logic                     out_stall;
    logic signed [WORD_W-1:0] pop_value;
    logic                     was_empty;
    logic                     was_full;
    logic [OCC_W-1:0]         occupancy;

    // Predictor state: a shadow copy of the circular store and its pointers.
    logic [WORD_W-1:0] shadow_words [DEPTH];
    int unsigned       shadow_head;
    int unsigned       shadow_tail;
    int unsigned       shadow_count;

    deque_result_t pending_results[$];

    int  mismatch_count;
    int  push_count;
    int  pop_count;
    int  empty_pop_count;
    int  dropped_push_count;
    bit  idle_enable;
    int  hold_left;

    ring_buffer_deque_top #(
        .CAPACITY(DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .action(action),
        .push_value(push_value),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .pop_value(pop_value),
        .was_empty(was_empty),
        .was_full(was_full),
        .occupancy(occupancy)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #(CLK_PERIOD / 2) clk = ~clk;
        end
    end

    // Applies one request to the shadow deque and returns what the block should answer.
    function automatic deque_result_t predict_deque_op(input action_t op,
                                                       input logic [WORD_W-1:0] value);
        deque_result_t res;
        res.pop_value = '0;
        res.was_empty = 1'b0;
        res.was_full  = 1'b0;
        case (op)
            ACT_PUSH_FRONT, ACT_PUSH_BACK:
            begin
                if (shadow_count >= DEPTH)
                begin
                    res.was_full = 1'b1;
                end
                else if (op == ACT_PUSH_FRONT)
                begin
                    shadow_head = (shadow_head == 0) ? DEPTH - 1 : shadow_head - 1;
                    shadow_words[shadow_head] = value;
                    shadow_count++;
                end
                else
                begin
                    shadow_words[shadow_tail] = value;
                    shadow_tail = (shadow_tail + 1 >= DEPTH) ? 0 : shadow_tail + 1;
                    shadow_count++;
                end
            end
            default:
            begin
                if (shadow_count == 0)
                begin
                    res.was_empty = 1'b1;
                    res.pop_value = EMPTY_VALUE;
                end
                else if (op == ACT_POP_FRONT)
                begin
                    res.pop_value = shadow_words[shadow_head];
                    shadow_head = (shadow_head + 1 >= DEPTH) ? 0 : shadow_head + 1;
                    shadow_count--;
                end
                else
                begin
                    shadow_tail = (shadow_tail == 0) ? DEPTH - 1 : shadow_tail - 1;
                    res.pop_value = shadow_words[shadow_tail];
                    shadow_count--;
                end
            end
        endcase
        res.occupancy = shadow_count[OCC_W-1:0];
        return res;
    endfunction

    // Checks each delivered result against the oldest prediction, then records new requests.
    always @(posedge clk)
    begin
        deque_result_t seen;
        deque_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            seen.pop_value = pop_value;
            seen.was_empty = was_empty;
            seen.was_full  = was_full;
            seen.occupancy = occupancy;
            if (pending_results.size() == 0)
            begin
                $error("Result with no request outstanding: pop_value %0d", seen.pop_value);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (seen.pop_value !== want.pop_value)
                begin
                    $error("pop_value: expected %0d, got %0d", want.pop_value, seen.pop_value);
                    mismatch_count++;
                end
                if (seen.was_empty !== want.was_empty)
                begin
                    $error("was_empty: expected %0b, got %0b", want.was_empty, seen.was_empty);
                    mismatch_count++;
                end
                if (seen.was_full !== want.was_full)
                begin
                    $error("was_full: expected %0b, got %0b", want.was_full, seen.was_full);
                    mismatch_count++;
                end
                if (seen.occupancy !== want.occupancy)
                begin
                    $error("occupancy: expected %0d, got %0d", want.occupancy, seen.occupancy);
                    mismatch_count++;
                end
            end
        end
        if (rst_n && in_valid && !in_stall)
        begin
            want = predict_deque_op(action_t'(action), push_value);
            pending_results.push_back(want);
            if (action == ACT_PUSH_FRONT || action == ACT_PUSH_BACK)
            begin
                push_count++;
                if (want.was_full)
                begin
                    dropped_push_count++;
                end
            end
            else
            begin
                pop_count++;
                if (want.was_empty)
                begin
                    empty_pop_count++;
                end
            end
        end
    end

    // Result side: a counted hold-off when one is requested, otherwise occasional stalls while idle_enable is set.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left = hold_left - 1;
            end
            else if (idle_enable && $urandom_range(99) < 6)
            begin
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // Offers one request and returns once the block has accepted it.
    task automatic send_request(input action_t op, input logic [WORD_W-1:0] value);
        @(negedge clk);
        while (idle_enable && $urandom_range(99) < 6)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        action     <= op;
        push_value <= value;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
    endtask

    // Stops offering requests and waits for every outstanding result plus the pipeline tail.
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [WORD_W-1:0] random_word();
        case ($urandom_range(15))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // Pops on the deque straight out of reset, from both ends.
    task automatic test_empty_pops();
        send_request(ACT_POP_FRONT, 32'h1234_5678);
        send_request(ACT_POP_BACK, 32'hFFFF_FFFF);
    endtask

    // Extreme words pushed at both ends and read back from both ends.
    task automatic test_extreme_words();
        send_request(ACT_PUSH_FRONT, 32'h7FFF_FFFF);
        send_request(ACT_PUSH_BACK, 32'h8000_0000);
        send_request(ACT_PUSH_FRONT, 32'hFFFF_FFFF);
        send_request(ACT_PUSH_BACK, 32'h0000_0000);
        send_request(ACT_POP_FRONT, 32'h0);
        send_request(ACT_POP_BACK, 32'h0);
        send_request(ACT_POP_FRONT, 32'h0);
        send_request(ACT_POP_BACK, 32'h0);
    endtask

    // Fills the deque to capacity, then offers pushes that must be dropped at both ends.
    task automatic test_full_drop();
        int i;
        for (i = 0; i < DEPTH; i++)
        begin
            send_request((i % 2 == 0) ? ACT_PUSH_BACK : ACT_PUSH_FRONT, random_word());
        end
        send_request(ACT_PUSH_FRONT, 32'hA5A5_A5A5);
        send_request(ACT_PUSH_BACK, 32'h5A5A_5A5A);
    endtask

    // The result side holds off for a long stretch while pushes keep arriving.
    task automatic test_output_backpressure();
        int i;
        hold_left = 80;
        for (i = 0; i < 30; i++)
        begin
            send_request(($urandom_range(1) == 0) ? ACT_PUSH_FRONT : ACT_PUSH_BACK,
                         random_word());
        end
        wait_drained();
    endtask

    // Random traffic in phases that are balanced or lean toward pushes or pops to reach full and empty often.
    task automatic test_random_traffic(input int num_requests);
        int      i;
        int      push_pct;
        action_t op;
        push_pct = 50;
        for (i = 0; i < num_requests; i++)
        begin
            if (i % 60 == 0)
            begin
                case ($urandom_range(2))
                    0: push_pct = 25;
                    1: push_pct = 50;
                    default: push_pct = 75;
                endcase
            end
            // A long stretch with both sides running flat out.
            idle_enable = !(i >= num_requests / 3 && i < num_requests / 2);
            if ($urandom_range(99) < push_pct)
            begin
                op = ($urandom_range(1) == 0) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
            end
            else
            begin
                op = ($urandom_range(1) == 0) ? ACT_POP_FRONT : ACT_POP_BACK;
            end
            send_request(op, random_word());
            // Once, a quarter of the way through, the sender waits for every result before going on.
            if (i == num_requests / 4)
            begin
                wait_drained();
            end
        end
        idle_enable = 1'b1;
    endtask

    // Test sequence.
    initial
    begin
        int waited;
        rst_n              = 1'b0;
        in_valid           = 1'b0;
        action             = ACT_PUSH_FRONT;
        push_value         = '0;
        mismatch_count     = 0;
        push_count         = 0;
        pop_count          = 0;
        empty_pop_count    = 0;
        dropped_push_count = 0;
        idle_enable        = 1'b1;
        hold_left          = 0;
        shadow_head        = 0;
        shadow_tail        = 0;
        shadow_count       = 0;
        foreach (shadow_words[i])
        begin
            shadow_words[i] = '0;
        end
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_pops();
        test_extreme_words();
        test_full_drop();
        test_output_backpressure();
        test_random_traffic(1760);

        // Final drain with a bound; anything still outstanding is a failure.
        @(negedge clk);
        in_valid <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < 2000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (5) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $error("%0d results never arrived", pending_results.size());
            mismatch_count++;
        end

        $display("Ran %0d pushes and %0d pops at both ends of the deque,", push_count, pop_count);
        $display("including %0d pops on empty and %0d pushes dropped when full.",
                 empty_pop_count, dropped_push_count);
        if (mismatch_count == 0)
        begin
            $display("[ring_buffer_deque_top] OK");
        end
        else
        begin
            $display("[ring_buffer_deque_top] ERROR");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #2000000;
        $display("Timeout with %0d results outstanding", pending_results.size());
        $display("[ring_buffer_deque_top] ERROR");
        $finish;
    end

endmodule
